// File: rtl/fdsq_pkg.sv
// Shared types, constants and helpers for the fan duty sequencer.
`timescale 1ns / 1ps
package fdsq_pkg;

  // Duty limits in percent
  localparam logic [6:0] DUTY_MIN = 7'd30;
  localparam logic [6:0] DUTY_MAX = 7'd100;

  // Configuration register map: index = paddr[4:2]
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_START_DELAY = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFF_HOLD    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_DOWN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FAULT_TIME  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BUS_OFF     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TACH_LEVEL  = 3'd6;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_START_DELAY = 16'd250;
  localparam logic [15:0] RST_OFF_HOLD    = 16'd15000;
  localparam logic [15:0] RST_RAMP_DOWN   = 16'd50;
  localparam logic [15:0] RST_FAULT_TIME  = 16'd5000;
  localparam logic [15:0] RST_PWM_PERIOD  = 16'd1000;
  localparam logic [13:0] RST_BUS_OFF     = 14'd3400;

  // floor(x / 100) for x < 2^23 as (x * ceil(2^30 / 100)) >> 30
  localparam int unsigned PROD_W      = 23;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  typedef logic [6:0] duty_t;

  function automatic duty_t clamp_duty(input logic [15:0] d);
    duty_t res;
    if (d < 16'(DUTY_MIN)) begin
      res = DUTY_MIN;
    end else if (d > 16'(DUTY_MAX)) begin
      res = DUTY_MAX;
    end else begin
      res = d[6:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/fan_duty_sequencer_with_stall_alarm_core.sv
// Top level of the two-fan duty sequencer with stall alarms.
`timescale 1ns / 1ps
// Usage:
//   Tick requests enter on the in_ channel (valid/ready). in_req_type = 1 is a
//   control tick that sequences the fan duty from fan_request, duty_request
//   and bus_voltage; in_req_type = 0 is a fast tick that samples both tach
//   levels for stall detection. Every request yields exactly one result on
//   the out_ channel: PWM enable, PWM compare, applied duty and both alarms.
//   Configuration goes through the APB-style port, registers at 4*index; the
//   user must write it only while no request is in flight, as the block does not enforce this.
// Pipeline and throughput:
//   Three stages: input register, state update plus duty*period, then the
//   divide by 100 into the result register. One request per cycle is
//   sustained while out_ready stays high.
// Stall behavior:
//   Each stage advances on its own when the next one is empty or moving, so
//   a held result still lets up to two more requests enter. in_ready drops
//   only once all three stages are full and out_ready is low.
// Reset:
//   rst_n (synchronous, active low) restores register defaults, clears all
//   sequencing state, stall counters and the sticky alarms, and empties
//   the pipeline. Alarms clear only by reset.
module fan_duty_sequencer_with_stall_alarm_core
  import fdsq_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic                  in_fan_request,
  input  logic [15:0]           in_duty_request,
  input  logic [13:0]           in_bus_voltage,
  input  logic                  in_fan1_tach_level,
  input  logic                  in_fan2_tach_level,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pwm_enable,
  output logic [15:0]           out_pwm_compare,
  output logic [6:0]            out_applied_duty,
  output logic                  out_fan1_alarm,
  output logic                  out_fan2_alarm,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Stall counters and fault time compare at the wider of the two widths
  localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] start_delay_r, off_hold_r, ramp_down_r, fault_time_r, pwm_period_r;
  logic [13:0] bus_off_r;
  logic        tach_level_r;
  logic        cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[REG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r <= RST_START_DELAY;
      off_hold_r    <= RST_OFF_HOLD;
      ramp_down_r   <= RST_RAMP_DOWN;
      fault_time_r  <= RST_FAULT_TIME;
      pwm_period_r  <= RST_PWM_PERIOD;
      bus_off_r     <= RST_BUS_OFF;
      tach_level_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_DELAY: start_delay_r <= pwdata[15:0];
        REG_OFF_HOLD:    off_hold_r    <= pwdata[15:0];
        REG_RAMP_DOWN:   ramp_down_r   <= pwdata[15:0];
        REG_FAULT_TIME:  fault_time_r  <= pwdata[15:0];
        REG_PWM_PERIOD:  pwm_period_r  <= pwdata[15:0];
        REG_BUS_OFF:     bus_off_r     <= pwdata[13:0];
        REG_TACH_LEVEL:  tach_level_r  <= pwdata[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Read back is combinational; APB samples prdata in the access cycle
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_START_DELAY: prdata = 32'(start_delay_r);
      REG_OFF_HOLD:    prdata = 32'(off_hold_r);
      REG_RAMP_DOWN:   prdata = 32'(ramp_down_r);
      REG_FAULT_TIME:  prdata = 32'(fault_time_r);
      REG_PWM_PERIOD:  prdata = 32'(pwm_period_r);
      REG_BUS_OFF:     prdata = 32'(bus_off_r);
      REG_TACH_LEVEL:  prdata = 32'(tach_level_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage moves when the next one has room
  // ---------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, out_valid_r;
  logic out_free, s2_free, s1_free, s1_move, in_take;

  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_vld_r || out_free;
  assign s1_free  = !s1_vld_r || s2_free;
  assign s1_move  = s1_vld_r && s2_free;
  assign in_take  = in_valid && s1_free;
  assign in_ready = s1_free;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_vld_r    <= in_valid;
      if (s2_free)  s2_vld_r    <= s1_vld_r;
      if (out_free) out_valid_r <= s2_vld_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic        s1_ctrl_r, s1_fan_req_r, s1_tach1_r, s1_tach2_r;
  logic [15:0] s1_duty_req_r;
  logic [13:0] s1_vbus_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ctrl_r     <= in_req_type;
      s1_fan_req_r  <= in_fan_request;
      s1_duty_req_r <= in_duty_request;
      s1_vbus_r     <= in_bus_voltage;
      s1_tach1_r    <= in_fan1_tach_level;
      s1_tach2_r    <= in_fan2_tach_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing state, committed when the request leaves stage 1
  // ---------------------------------------------------------------------------
  logic        run_r, run_nxt;
  logic        armed_r, armed_nxt;
  logic        pwm_on_r, pwm_on_nxt;
  duty_t       soft_duty_r, soft_duty_nxt;
  duty_t       stop_duty_r, stop_duty_nxt;
  logic [15:0] wait_cnt_r, wait_cnt_nxt;
  logic [15:0] hold_cnt_r, hold_cnt_nxt;
  logic [15:0] ramp_cnt_r, ramp_cnt_nxt;
  logic [COUNT_WIDTH-1:0] stall_cnt_r [2];
  logic [COUNT_WIDTH-1:0] stall_cnt_nxt [2];
  logic [1:0]  alarm_r, alarm_nxt;

  duty_t       duty_set, duty_step;
  logic [15:0] ramp_inc;
  logic [1:0]  tach;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign tach = {s1_tach2_r, s1_tach1_r};

  always_comb begin
    run_nxt       = run_r;
    armed_nxt     = armed_r;
    pwm_on_nxt    = pwm_on_r;
    soft_duty_nxt = soft_duty_r;
    stop_duty_nxt = stop_duty_r;
    wait_cnt_nxt  = wait_cnt_r;
    hold_cnt_nxt  = hold_cnt_r;
    ramp_cnt_nxt  = ramp_cnt_r;
    stall_cnt_nxt = stall_cnt_r;
    alarm_nxt     = alarm_r;
    duty_set      = clamp_duty(s1_duty_req_r);
    duty_step     = soft_duty_r;
    ramp_inc      = ramp_cnt_r + 16'd1;
    cnt_inc       = '0;

    if (s1_ctrl_r) begin
      run_nxt = s1_fan_req_r;
      if (s1_fan_req_r) begin
        // Running: wait out the start delay, then slew one percent per tick
        pwm_on_nxt = 1'b1;
        if (wait_cnt_r > start_delay_r) begin
          if (soft_duty_r < duty_set) begin
            duty_step = soft_duty_r + 7'd1;
          end else if (soft_duty_r > duty_set) begin
            duty_step = soft_duty_r - 7'd1;
          end
          armed_nxt = 1'b1;
        end else if (wait_cnt_r != 16'hFFFF) begin
          wait_cnt_nxt = wait_cnt_r + 16'd1;
        end
        soft_duty_nxt = clamp_duty(16'(duty_step));
        stop_duty_nxt = soft_duty_nxt;
        hold_cnt_nxt  = '0;
      end else begin
        wait_cnt_nxt = '0;
        if (s1_vbus_r < bus_off_r || hold_cnt_r >= off_hold_r) begin
          // Bus too low or hold time over: cut the fans at once
          hold_cnt_nxt  = '0;
          ramp_cnt_nxt  = '0;
          stop_duty_nxt = '0;
          pwm_on_nxt    = 1'b0;
          armed_nxt     = 1'b0;
        end else begin
          // Keep running and ramp down one percent per ramp interval
          hold_cnt_nxt = hold_cnt_r + 16'd1;
          if (stop_duty_r > DUTY_MIN) begin
            ramp_cnt_nxt = ramp_inc;
            if (ramp_inc >= ramp_down_r) begin
              ramp_cnt_nxt  = '0;
              stop_duty_nxt = stop_duty_r - 7'd1;
            end
          end else begin
            stop_duty_nxt = DUTY_MIN;
          end
          stop_duty_nxt = clamp_duty(16'(stop_duty_nxt));
        end
        soft_duty_nxt = stop_duty_nxt;
      end
    end else begin
      // Fast tick: count fault-level tach samples while armed and running
      if (run_r && (soft_duty_r != '0) && armed_r) begin
        for (int i = 0; i < 2; i++) begin
          if (!alarm_r[i]) begin
            if (tach[i] == tach_level_r) begin
              cnt_inc = (stall_cnt_r[i] == CNT_MAX) ? stall_cnt_r[i]
                                                    : stall_cnt_r[i] + COUNT_WIDTH'(1);
              if (CMP_W'(cnt_inc) >= CMP_W'(fault_time_r)) begin
                stall_cnt_nxt[i] = '0;
                alarm_nxt[i]     = 1'b1;
              end else begin
                stall_cnt_nxt[i] = cnt_inc;
              end
            end else begin
              stall_cnt_nxt[i] = '0;
            end
          end
        end
      end else begin
        stall_cnt_nxt[0] = '0;
        stall_cnt_nxt[1] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r          <= 1'b0;
      armed_r        <= 1'b0;
      pwm_on_r       <= 1'b0;
      soft_duty_r    <= '0;
      stop_duty_r    <= '0;
      wait_cnt_r     <= '0;
      hold_cnt_r     <= '0;
      ramp_cnt_r     <= '0;
      stall_cnt_r[0] <= '0;
      stall_cnt_r[1] <= '0;
      alarm_r        <= '0;
    end else if (s1_move) begin
      run_r          <= run_nxt;
      armed_r        <= armed_nxt;
      pwm_on_r       <= pwm_on_nxt;
      soft_duty_r    <= soft_duty_nxt;
      stop_duty_r    <= stop_duty_nxt;
      wait_cnt_r     <= wait_cnt_nxt;
      hold_cnt_r     <= hold_cnt_nxt;
      ramp_cnt_r     <= ramp_cnt_nxt;
      stall_cnt_r    <= stall_cnt_nxt;
      alarm_r        <= alarm_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: snapshot of the new state plus duty * period
  // ---------------------------------------------------------------------------
  logic              s2_ctrl_r, s2_pwm_on_r;
  duty_t             s2_duty_r;
  logic [1:0]        s2_alarm_r;
  logic [PROD_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_ctrl_r   <= s1_ctrl_r;
      s2_pwm_on_r <= pwm_on_nxt;
      s2_duty_r   <= soft_duty_nxt;
      s2_alarm_r  <= alarm_nxt;
      s2_prod_r   <= PROD_W'(soft_duty_nxt) * PROD_W'(pwm_period_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 100 through the reciprocal, load the result register.
  // The compare value only changes on control ticks; fast ticks hold it.
  // ---------------------------------------------------------------------------
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic        out_pwm_enable_r, out_fan1_alarm_r, out_fan2_alarm_r;
  logic [15:0] out_pwm_compare_r;
  duty_t       out_applied_duty_r;

  assign recip_prod = (PROD_W+RECIP_W)'(s2_prod_r) * (PROD_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_pwm_compare_r <= '0;
    end else if (out_free && s2_vld_r && s2_ctrl_r) begin
      out_pwm_compare_r <= recip_prod[RECIP_SHIFT +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_vld_r) begin
      out_pwm_enable_r   <= s2_pwm_on_r;
      out_applied_duty_r <= s2_duty_r;
      out_fan1_alarm_r   <= s2_alarm_r[0];
      out_fan2_alarm_r   <= s2_alarm_r[1];
    end
  end

  assign out_pwm_enable   = out_pwm_enable_r;
  assign out_pwm_compare  = out_pwm_compare_r;
  assign out_applied_duty = out_applied_duty_r;
  assign out_fan1_alarm   = out_fan1_alarm_r;
  assign out_fan2_alarm   = out_fan2_alarm_r;

endmodule

// File: rtl/fdsq_checker.sv
// Port-level checker for the fan duty sequencer and its bind statement.
`timescale 1ns / 1ps
module fdsq_checker
  import fdsq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_pwm_enable,
  input logic [15:0] out_pwm_compare,
  input logic [6:0]  out_applied_duty,
  input logic        out_fan1_alarm,
  input logic        out_fan2_alarm
);

  logic seen1_r, seen2_r;

  // Remember alarms already delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen1_r <= 1'b0;
      seen2_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen1_r <= seen1_r || out_fan1_alarm;
      seen2_r <= seen2_r || out_fan2_alarm;
    end
  end

  a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((!seen1_r || out_fan1_alarm) && (!seen2_r || out_fan2_alarm)))
    else $error("fan alarm dropped without reset");

  // Zero duty only follows reset or a cut, both of which stop the PWM
  a_zero_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_applied_duty == '0) |-> (out_pwm_compare == '0 && !out_pwm_enable))
    else $error("zero duty with PWM running or nonzero compare");

  a_on_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pwm_enable) |->
      (out_applied_duty >= DUTY_MIN && out_applied_duty <= DUTY_MAX))
    else $error("running duty outside 30..100");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pwm_compare)
                                   && $stable(out_applied_duty)))
    else $error("stalled result changed");

endmodule

bind fan_duty_sequencer_with_stall_alarm_core fdsq_checker u_fdsq_checker (.*);
